// ----- rtl/art_pkg.sv -----
`timescale 1ns / 1ps

package art_pkg;

   localparam int MAC_BYTES  = 6;
   localparam int MAC_W      = MAC_BYTES * 8;
   localparam int ADDR_W     = 32;
   localparam int TIME_W     = 32;
   localparam int HOP_W      = 8;
   localparam int REQ_HOP_W  = HOP_W + 1;
   localparam int KIND_W     = 3;
   localparam int COUNT_W    = 5;
   localparam int LIMIT_W    = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_UPDATE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CONFIRM = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PURGE   = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd6;

   // register index, taken from paddr above the byte lanes
   localparam logic CSR_IDX_STALE_LIMIT = 1'b0;

   localparam logic [LIMIT_W-1:0] STALE_LIMIT_RESET = 16'd30;
   localparam logic [COUNT_W-1:0] REMOVED_MAX       = 5'd31;
   localparam logic [COUNT_W-1:0] REMOVED_ONE       = 5'd1;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] dest;
      logic [MAC_W-1:0]  next_hop;
      logic [HOP_W-1:0]  port;
      logic [HOP_W-1:0]  distance;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ----- rtl/art_ram.sv -----
`timescale 1ns / 1ps

module art_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/aging_route_table_core.sv -----
`timescale 1ns / 1ps

// Aging route table: up to TABLE_SLOTS routes keyed by destination address.
// Request channel (req_*): one word per operation (lookup, add, update,
// confirm, delete, purge stale, clear). Response channel (rsp_*): exactly one
// word per request, in request order. Both use valid/ready.
// csr_* is an APB-style port holding stale_limit at byte address 0.
// All slots live in one single-port-write RAM with a registered read. Every
// operation sweeps the whole RAM, one slot a cycle, then finishes with at
// most one write-back. The response word is registered onto rsp_*, and a
// new request is taken only once the one before it has finished; the RAM
// sweep sets the pace.
// Reset runs a clearing pass that marks every slot empty; req_ready stays
// low meanwhile, CSR writes are taken as ever.
// The response sits in an output register: the next request is accepted
// while it waits, and a finished operation holds before its write-back until
// the output register is free, so a stalled receiver loses nothing.
module aging_route_table_core
   import art_pkg::*;
#(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [KIND_W-1:0]           req_kind,
   input  logic [ADDR_W-1:0]           req_dest_addr,
   input  logic [MAC_W-1:0]            req_next_hop_mac,
   input  logic signed [REQ_HOP_W-1:0] req_out_port,
   input  logic signed [REQ_HOP_W-1:0] req_hop_distance,
   input  logic [TIME_W-1:0]           req_now,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic [MAC_W-1:0]            rsp_found_next_hop,
   output logic [HOP_W-1:0]            rsp_found_port,
   output logic [HOP_W-1:0]            rsp_found_distance,
   output logic                        rsp_same_route,
   output logic [COUNT_W-1:0]          rsp_removed_count,
   output logic                        rsp_table_full,
   // configuration port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [CSR_DATA_W-1:0]       csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W  = SLOT_W + 1;
   localparam logic [CNT_W-1:0]  SLOT_COUNT = CNT_W'(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);

   typedef enum logic [3:0] {
      ST_INIT   = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // control
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  init_cnt_ff, init_cnt_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0] rd_idx_ff, rd_idx_in;
   logic              found_ff, found_in;
   logic              free_found_ff, free_found_in;
   logic [COUNT_W-1:0] removed_ff, removed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0] stale_limit_ff, stale_limit_in;

   // payload
   logic [KIND_W-1:0]           kind_ff, kind_in;
   logic [ADDR_W-1:0]           key_ff, key_in;
   logic [MAC_W-1:0]            mac_ff, mac_in;
   logic signed [REQ_HOP_W-1:0] port_ff, port_in;
   logic signed [REQ_HOP_W-1:0] dist_ff, dist_in;
   logic [TIME_W-1:0]           now_ff, now_in;
   logic [SLOT_W-1:0]           hit_slot_ff, hit_slot_in;
   entry_type                   hit_entry_ff, hit_entry_in;
   logic [SLOT_W-1:0]           free_slot_ff, free_slot_in;

   logic                rsp_hit_ff, rsp_hit_in;
   logic [MAC_W-1:0]    rsp_mac_ff, rsp_mac_in;
   logic [HOP_W-1:0]    rsp_port_ff, rsp_port_in;
   logic [HOP_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                rsp_same_ff, rsp_same_in;
   logic [COUNT_W-1:0]  rsp_removed_ff, rsp_removed_in;
   logic                rsp_full_ff, rsp_full_in;

   // RAM port
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   entry_type         rd_entry;
   entry_type         new_entry;
   logic              csr_write;
   logic              req_accept;
   logic              rsp_free;
   logic              scan_done;
   logic              slot_stale;
   logic              slot_drop;
   logic [TIME_W-1:0] slot_age;

   art_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry   = entry_type'(ram_rd_data);
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign scan_done  = rd_vld_ff && (rd_idx_ff == LAST_SLOT);

   // age wraps modulo 2^32, as the time stamps do
   assign slot_age   = now_ff - rd_entry.stamp;
   assign slot_stale = rd_entry.valid && (slot_age > TIME_W'(stale_limit_ff));
   assign slot_drop  = rd_vld_ff &&
                       (((kind_ff == KIND_PURGE) && slot_stale) ||
                        ((kind_ff == KIND_CLEAR) && rd_entry.valid));

   // ---------------------------------------------------------------------
   // Configuration port: zero-wait, write on the access phase
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      stale_limit_in = stale_limit_ff;
      if (csr_write && (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_STALE_LIMIT)) begin
         stale_limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_STALE_LIMIT) begin
         csr_prdata = CSR_DATA_W'(stale_limit_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Entry written back at the end of an add, update, confirm or delete
   // ---------------------------------------------------------------------
   always_comb begin
      new_entry = hit_entry_ff;
      unique case (kind_ff)
         KIND_ADD: begin
            new_entry.valid    = 1'b1;
            new_entry.dest     = key_ff;
            new_entry.next_hop = mac_ff;
            // negative port or distance is stored as zero
            new_entry.port     = port_ff[REQ_HOP_W-1] ? '0 : port_ff[HOP_W-1:0];
            new_entry.distance = dist_ff[REQ_HOP_W-1] ? '0 : dist_ff[HOP_W-1:0];
            new_entry.stamp    = now_ff;
         end
         KIND_UPDATE: begin
            // a zero first octet, or a negative port or distance, keeps the old value
            if (mac_ff[MAC_W-1 -: 8] != 8'd0) begin
               new_entry.next_hop = mac_ff;
            end
            if (!port_ff[REQ_HOP_W-1]) begin
               new_entry.port = port_ff[HOP_W-1:0];
            end
            if (!dist_ff[REQ_HOP_W-1]) begin
               new_entry.distance = dist_ff[HOP_W-1:0];
            end
            new_entry.stamp = now_ff;
         end
         KIND_CONFIRM: begin
            new_entry.stamp = now_ff;
         end
         KIND_DELETE: begin
            new_entry.valid = 1'b0;
         end
         default: begin
            new_entry = hit_entry_ff;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: clearing pass, sweep, write-back and response
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      init_cnt_in   = init_cnt_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      removed_in    = removed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      kind_in      = kind_ff;
      key_in       = key_ff;
      mac_in       = mac_ff;
      port_in      = port_ff;
      dist_in      = dist_ff;
      now_in       = now_ff;
      hit_slot_in  = hit_slot_ff;
      hit_entry_in = hit_entry_ff;
      free_slot_in = free_slot_ff;

      rsp_hit_in     = rsp_hit_ff;
      rsp_mac_in     = rsp_mac_ff;
      rsp_port_in    = rsp_port_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_same_in    = rsp_same_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_full_in    = rsp_full_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = rd_idx_ff;
      ram_wr_data = rd_entry;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_cnt_ff[SLOT_W-1:0];

      unique case (state_ff)
         ST_INIT: begin
            // mark one slot empty per cycle
            ram_wr_en         = 1'b1;
            ram_wr_addr       = init_cnt_ff[SLOT_W-1:0];
            ram_wr_data       = '0;
            init_cnt_in       = init_cnt_ff + 1'b1;
            if (init_cnt_ff[SLOT_W-1:0] == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_accept) begin
               kind_in       = req_kind;
               key_in        = req_dest_addr;
               mac_in        = req_next_hop_mac;
               port_in       = req_out_port;
               dist_in       = req_hop_distance;
               now_in        = req_now;
               rd_cnt_in     = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               removed_in    = '0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue reads ahead; evaluate the slot whose data has returned
            if (rd_cnt_ff < SLOT_COUNT) begin
               ram_rd_en = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = rd_cnt_ff[SLOT_W-1:0];
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_entry.valid && (rd_entry.dest == key_ff) && !found_ff) begin
                  found_in     = 1'b1;
                  hit_slot_in  = rd_idx_ff;
                  hit_entry_in = rd_entry;
               end
               if (!rd_entry.valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = rd_idx_ff;
               end
               // drop stale or cleared slots in place; the read side is
               // already past this slot, so no hazard
               if (slot_drop) begin
                  ram_wr_en         = 1'b1;
                  ram_wr_data.valid = 1'b0;
                  if (removed_ff != REMOVED_MAX) begin
                     removed_in = removed_ff + 1'b1;
                  end
               end
            end
            if (scan_done) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // hold the write-back until the output register is free
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = 1'b0;
               rsp_mac_in     = '0;
               rsp_port_in    = '0;
               rsp_dist_in    = '0;
               rsp_same_in    = 1'b0;
               rsp_removed_in = '0;
               rsp_full_in    = 1'b0;
               ram_wr_addr    = hit_slot_ff;
               ram_wr_data    = new_entry;
               state_in       = ST_IDLE;
               unique case (kind_ff)
                  KIND_LOOKUP: begin
                     if (found_ff) begin
                        rsp_hit_in  = 1'b1;
                        rsp_mac_in  = hit_entry_ff.next_hop;
                        rsp_port_in = hit_entry_ff.port;
                        rsp_dist_in = hit_entry_ff.distance;
                        rsp_same_in = (hit_entry_ff.next_hop == mac_ff) &&
                                      !port_ff[REQ_HOP_W-1] && !dist_ff[REQ_HOP_W-1] &&
                                      (hit_entry_ff.port == port_ff[HOP_W-1:0]) &&
                                      (hit_entry_ff.distance == dist_ff[HOP_W-1:0]);
                     end
                  end
                  KIND_ADD: begin
                     if (found_ff || free_found_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = found_ff ? hit_slot_ff : free_slot_ff;
                        rsp_hit_in  = found_ff;
                        rsp_mac_in  = new_entry.next_hop;
                        rsp_port_in = new_entry.port;
                        rsp_dist_in = new_entry.distance;
                     end else begin
                        rsp_full_in = 1'b1;
                     end
                  end
                  KIND_UPDATE, KIND_CONFIRM: begin
                     if (found_ff) begin
                        ram_wr_en   = 1'b1;
                        rsp_hit_in  = 1'b1;
                        rsp_mac_in  = new_entry.next_hop;
                        rsp_port_in = new_entry.port;
                        rsp_dist_in = new_entry.distance;
                     end
                  end
                  KIND_DELETE: begin
                     if (found_ff) begin
                        ram_wr_en      = 1'b1;
                        rsp_hit_in     = 1'b1;
                        rsp_mac_in     = hit_entry_ff.next_hop;
                        rsp_port_in    = hit_entry_ff.port;
                        rsp_dist_in    = hit_entry_ff.distance;
                        rsp_removed_in = REMOVED_ONE;
                     end
                  end
                  KIND_PURGE, KIND_CLEAR: begin
                     rsp_removed_in = removed_ff;
                  end
                  default: begin
                     // unused code: answer with an all-zero word
                     rsp_hit_in = 1'b0;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         init_cnt_ff    <= '0;
         rd_cnt_ff      <= '0;
         rd_vld_ff      <= 1'b0;
         found_ff       <= 1'b0;
         free_found_ff  <= 1'b0;
         removed_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         stale_limit_ff <= STALE_LIMIT_RESET;
      end else begin
         state_ff       <= state_in;
         init_cnt_ff    <= init_cnt_in;
         rd_cnt_ff      <= rd_cnt_in;
         rd_vld_ff      <= rd_vld_in;
         found_ff       <= found_in;
         free_found_ff  <= free_found_in;
         removed_ff     <= removed_in;
         rsp_valid_ff   <= rsp_valid_in;
         stale_limit_ff <= stale_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff      <= rd_idx_in;
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      mac_ff         <= mac_in;
      port_ff        <= port_in;
      dist_ff        <= dist_in;
      now_ff         <= now_in;
      hit_slot_ff    <= hit_slot_in;
      hit_entry_ff   <= hit_entry_in;
      free_slot_ff   <= free_slot_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_mac_ff     <= rsp_mac_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_same_ff    <= rsp_same_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_found_next_hop = rsp_mac_ff;
   assign rsp_found_port     = rsp_port_ff;
   assign rsp_found_distance = rsp_dist_ff;
   assign rsp_same_route     = rsp_same_ff;
   assign rsp_removed_count  = rsp_removed_ff;
   assign rsp_table_full     = rsp_full_ff;

endmodule

// ----- rtl/art_checker.sv -----
`timescale 1ns / 1ps

module art_checker
   import art_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_hit,
   input logic [MAC_W-1:0]            rsp_found_next_hop,
   input logic [HOP_W-1:0]            rsp_found_port,
   input logic [HOP_W-1:0]            rsp_found_distance,
   input logic                        rsp_same_route,
   input logic [COUNT_W-1:0]          rsp_removed_count,
   input logic                        rsp_table_full
);

   // one operation at a time: no accept in the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while the previous one is in progress");

   // a dropped add reports nothing else
   a_full_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_hit && !rsp_same_route &&
         rsp_removed_count == '0 && rsp_found_next_hop == '0 &&
         rsp_found_port == '0 && rsp_found_distance == '0)
      else $error("table full response carries other fields");

   a_same_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_same_route |-> rsp_hit)
      else $error("same route reported without a hit");

   // more than one removal comes only from purge or clear, which report no entry
   a_bulk_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed_count > REMOVED_ONE |-> !rsp_hit &&
         rsp_found_next_hop == '0 && rsp_found_port == '0)
      else $error("bulk removal reports an entry");

   // reset empties the output and starts the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity in the cycle after reset");

endmodule

bind aging_route_table_core art_checker u_art_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import art_pkg::*;

   localparam int SLOTS       = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int KEY_POOL    = 24;
   localparam int PHASE_ITEMS = 100;
   localparam int PHASES      = 6;
   // a long receiver hold-off starts once this many response words are checked
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_TAIL  = 40;
   localparam int SIGN        = REQ_HOP_W - 1;
   localparam int SENDER      = 0;
   localparam int RECEIVER    = 1;

   // kind 7 has no operation behind it: the block answers with an all-zero word
   localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
   localparam logic signed [REQ_HOP_W-1:0] HOP_NEGATIVE = -9'sd1;
   localparam logic [CSR_ADDR_W-1:0] STALE_LIMIT_ADDR = {CSR_IDX_STALE_LIMIT, 2'b00};

   typedef struct packed {
      logic [KIND_W-1:0]           kind;
      logic [ADDR_W-1:0]           dest;
      logic [MAC_W-1:0]            mac;
      logic signed [REQ_HOP_W-1:0] port;
      logic signed [REQ_HOP_W-1:0] hop_dist;
      logic [TIME_W-1:0]           now;
   } route_req_type;

   typedef struct packed {
      logic               hit;
      logic [MAC_W-1:0]   next_hop;
      logic [HOP_W-1:0]   port;
      logic [HOP_W-1:0]   distance;
      logic               same_route;
      logic [COUNT_W-1:0] removed;
      logic               table_full;
   } route_rsp_type;

   // ---------------------------------------------------------------------
   // Clock, reset and every input of the block, known from time zero
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid        = 1'b0;
   logic                        req_ready;
   logic [KIND_W-1:0]           req_kind         = '0;
   logic [ADDR_W-1:0]           req_dest_addr    = '0;
   logic [MAC_W-1:0]            req_next_hop_mac = '0;
   logic signed [REQ_HOP_W-1:0] req_out_port     = '0;
   logic signed [REQ_HOP_W-1:0] req_hop_distance = '0;
   logic [TIME_W-1:0]           req_now          = '0;

   logic                        rsp_valid;
   logic                        rsp_ready        = 1'b0;
   logic                        rsp_hit;
   logic [MAC_W-1:0]            rsp_found_next_hop;
   logic [HOP_W-1:0]            rsp_found_port;
   logic [HOP_W-1:0]            rsp_found_distance;
   logic                        rsp_same_route;
   logic [COUNT_W-1:0]          rsp_removed_count;
   logic                        rsp_table_full;

   logic                        csr_psel         = 1'b0;
   logic                        csr_penable      = 1'b0;
   logic                        csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0]       csr_paddr        = '0;
   logic [CSR_DATA_W-1:0]       csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0]       csr_prdata;
   logic                        csr_pready;

   always #6 clock = ~clock;

   aging_route_table_core #(
      .TABLE_SLOTS(SLOTS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_dest_addr     (req_dest_addr),
      .req_next_hop_mac  (req_next_hop_mac),
      .req_out_port      (req_out_port),
      .req_hop_distance  (req_hop_distance),
      .req_now           (req_now),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_found_next_hop(rsp_found_next_hop),
      .rsp_found_port    (rsp_found_port),
      .rsp_found_distance(rsp_found_distance),
      .rsp_same_route    (rsp_same_route),
      .rsp_removed_count (rsp_removed_count),
      .rsp_table_full    (rsp_table_full),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // ---------------------------------------------------------------------
   // Shadow route table, updated as each request word is accepted
   // ---------------------------------------------------------------------
   logic               tab_valid    [SLOTS];
   logic [ADDR_W-1:0]  tab_dest     [SLOTS];
   logic [MAC_W-1:0]   tab_next_hop [SLOTS];
   logic [HOP_W-1:0]   tab_port     [SLOTS];
   logic [HOP_W-1:0]   tab_distance [SLOTS];
   logic [TIME_W-1:0]  tab_stamp    [SLOTS];
   logic [LIMIT_W-1:0] stale_limit_q = STALE_LIMIT_RESET;

   route_req_type pending_reqs  [$];
   route_rsp_type expected_rsps [$];

   int errors        = 0;
   int results_seen  = 0;
   int cycle_count   = 0;
   int idle_burst [2] = '{0, 0};

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tab_valid[i]    = 1'b0;
         tab_dest[i]     = '0;
         tab_next_hop[i] = '0;
         tab_port[i]     = '0;
         tab_distance[i] = '0;
         tab_stamp[i]    = '0;
      end
   end

   // Apply one operation to the shadow table and return the response word it causes.
   function automatic route_rsp_type apply_route_op(route_req_type r);
      route_rsp_type     o;
      int                match;
      int                slot;
      int                removed;
      logic [TIME_W-1:0] age;
      o       = '0;
      match   = -1;
      removed = 0;
      for (int i = 0; i < SLOTS; i++)
         if (match < 0 && tab_valid[i] && tab_dest[i] == r.dest) match = i;
      // slot whose contents are reported in the word; -1 reports nothing
      slot = match;
      case (r.kind)
         KIND_LOOKUP: begin
            if (match >= 0)
               o.same_route = tab_next_hop[match] == r.mac && !r.port[SIGN] &&
                              !r.hop_dist[SIGN] && tab_port[match] == r.port[HOP_W-1:0] &&
                              tab_distance[match] == r.hop_dist[HOP_W-1:0];
         end
         KIND_ADD: begin
            // a present key is overwritten in place, else take the lowest free slot
            if (slot < 0)
               for (int i = 0; i < SLOTS; i++)
                  if (slot < 0 && !tab_valid[i]) slot = i;
            if (slot < 0) begin
               o.table_full = 1'b1;
            end else begin
               tab_valid[slot]    = 1'b1;
               tab_dest[slot]     = r.dest;
               tab_next_hop[slot] = r.mac;
               tab_port[slot]     = r.port[SIGN] ? '0 : r.port[HOP_W-1:0];
               tab_distance[slot] = r.hop_dist[SIGN] ? '0 : r.hop_dist[HOP_W-1:0];
               tab_stamp[slot]    = r.now;
            end
         end
         KIND_UPDATE: begin
            if (match >= 0) begin
               if (r.mac[MAC_W-1 -: 8] != 8'h00) tab_next_hop[match] = r.mac;
               if (!r.port[SIGN]) tab_port[match] = r.port[HOP_W-1:0];
               if (!r.hop_dist[SIGN]) tab_distance[match] = r.hop_dist[HOP_W-1:0];
               tab_stamp[match] = r.now;
            end
         end
         KIND_CONFIRM: begin
            if (match >= 0) tab_stamp[match] = r.now;
         end
         KIND_DELETE: begin
            // the word still reports the removed entry
            if (match >= 0) begin
               tab_valid[match] = 1'b0;
               removed = 1;
            end
         end
         KIND_PURGE: begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
               age = r.now - tab_stamp[i];
               if (tab_valid[i] && age > TIME_W'(stale_limit_q)) begin
                  tab_valid[i] = 1'b0;
                  removed++;
               end
            end
         end
         KIND_CLEAR: begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++)
               if (tab_valid[i]) begin
                  tab_valid[i] = 1'b0;
                  removed++;
               end
         end
         default: slot = -1;
      endcase
      if (slot >= 0) begin
         o.hit      = match >= 0;
         o.next_hop = tab_next_hop[slot];
         o.port     = tab_port[slot];
         o.distance = tab_distance[slot];
      end
      o.removed = (removed > REMOVED_MAX) ? REMOVED_MAX : COUNT_W'(removed);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------
   // Most requests name one of a small pool of keys, each with its usual
   // route, so that hits, exact-route lookups and a full table come often.
   logic [ADDR_W-1:0]           pool_key  [KEY_POOL];
   logic [MAC_W-1:0]            pool_mac  [KEY_POOL];
   logic signed [REQ_HOP_W-1:0] pool_port [KEY_POOL];
   logic signed [REQ_HOP_W-1:0] pool_dist [KEY_POOL];
   logic [TIME_W-1:0]           gen_now = '0;

   function automatic logic signed [REQ_HOP_W-1:0] random_hop();
      if ($urandom_range(7, 0) == 0) return HOP_NEGATIVE;
      return {1'b0, HOP_W'($urandom)};
   endfunction

   function automatic route_req_type make_req(logic [KIND_W-1:0] kind,
                                              logic [ADDR_W-1:0] dest,
                                              logic [MAC_W-1:0] mac,
                                              logic signed [REQ_HOP_W-1:0] port,
                                              logic signed [REQ_HOP_W-1:0] hop_dist,
                                              logic [TIME_W-1:0] now);
      route_req_type r;
      r.kind     = kind;
      r.dest     = dest;
      r.mac      = mac;
      r.port     = port;
      r.hop_dist = hop_dist;
      r.now      = now;
      return r;
   endfunction

   function automatic route_req_type next_random_req();
      route_req_type r;
      int            roll;
      int            k;
      roll = $urandom_range(99, 0);
      if (roll < 34)      r.kind = KIND_ADD;
      else if (roll < 54) r.kind = KIND_LOOKUP;
      else if (roll < 66) r.kind = KIND_UPDATE;
      else if (roll < 76) r.kind = KIND_CONFIRM;
      else if (roll < 87) r.kind = KIND_DELETE;
      else if (roll < 94) r.kind = KIND_PURGE;
      else if (roll < 97) r.kind = KIND_CLEAR;
      else                r.kind = KIND_UNUSED;
      k = $urandom_range(KEY_POOL - 1, 0);
      r.dest = ($urandom_range(9, 0) == 0) ? ADDR_W'($urandom) : pool_key[k];
      if ($urandom_range(2, 0) != 0) begin
         r.mac      = pool_mac[k];
         r.port     = pool_port[k];
         r.hop_dist = pool_dist[k];
      end else begin
         r.mac      = MAC_W'({$urandom, $urandom});
         r.port     = random_hop();
         r.hop_dist = random_hop();
      end
      // keep the stored MAC on some updates
      if (r.kind == KIND_UPDATE && $urandom_range(3, 0) == 0) r.mac[MAC_W-1 -: 8] = 8'h00;
      // time mostly creeps, now and then leaps past any stale limit
      roll = $urandom_range(99, 0);
      if (roll < 85)      gen_now += $urandom_range(4, 0);
      else if (roll < 95) gen_now += $urandom_range(40, 0);
      else                gen_now += $urandom_range(80000, 0);
      r.now = ($urandom_range(49, 0) == 0) ? TIME_W'($urandom) : gen_now;
      return r;
   endfunction

   // Idle cycles after one word: mostly none or a few, seldom many, with
   // stretches of back-to-back words.
   function automatic int pick_idle(int side);
      int roll;
      if (idle_burst[side] > 0) begin
         idle_burst[side]--;
         return 0;
      end
      roll = $urandom_range(99, 0);
      if (roll < 4) begin
         idle_burst[side] = $urandom_range(40, 20);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(4, 1);
      return $urandom_range(60, 12);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: offer words from the pending queue, predict on accept
   // ---------------------------------------------------------------------
   route_req_type req_word;
   logic          req_fired;
   int            send_idle = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_idle = 0;
      end else begin
         req_fired = req_valid && req_ready;
         if (req_fired) begin
            expected_rsps.push_back(apply_route_op(req_word));
            send_idle = pick_idle(SENDER);
         end else if (!req_valid && send_idle > 0) begin
            send_idle--;
         end
         // hold the word until taken; advance to the next once the gap is spent
         if ((req_fired || !req_valid) && send_idle == 0 && pending_reqs.size() != 0) begin
            req_word = pending_reqs.pop_front();
            req_kind         <= req_word.kind;
            req_dest_addr    <= req_word.dest;
            req_next_hop_mac <= req_word.mac;
            req_out_port     <= req_word.port;
            req_hop_distance <= req_word.hop_dist;
            req_now          <= req_word.now;
            req_valid        <= 1'b1;
         end else if (req_fired) begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: check each word against the oldest prediction
   // ---------------------------------------------------------------------
   route_rsp_type rsp_want;
   int            recv_idle = 0;
   logic          long_hold_done = 1'b0;

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_idle = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response word with no request outstanding", $time);
               errors++;
            end else begin
               rsp_want = expected_rsps.pop_front();
               check_field("hit", 64'(rsp_want.hit), 64'(rsp_hit));
               check_field("found_next_hop", 64'(rsp_want.next_hop),
                           64'(rsp_found_next_hop));
               check_field("found_port", 64'(rsp_want.port), 64'(rsp_found_port));
               check_field("found_distance", 64'(rsp_want.distance),
                           64'(rsp_found_distance));
               check_field("same_route", 64'(rsp_want.same_route), 64'(rsp_same_route));
               check_field("removed_count", 64'(rsp_want.removed),
                           64'(rsp_removed_count));
               check_field("table_full", 64'(rsp_want.table_full), 64'(rsp_table_full));
            end
            results_seen++;
            recv_idle = pick_idle(RECEIVER);
            // hold off long enough for the block to fill and stall its input
            if (results_seen >= HOLD_AT && !long_hold_done) begin
               recv_idle      = HOLD_CYCLES;
               long_hold_done = 1'b1;
            end
         end else if (recv_idle > 0) begin
            recv_idle--;
         end
         rsp_ready <= (recv_idle == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: reset, directed words, then randomised phases
   // ---------------------------------------------------------------------
   // Wait until every queued word is taken and every response has come back.
   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   // Write stale_limit through the APB port, then read it back.
   task automatic write_stale_limit(logic [LIMIT_W-1:0] limit);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= STALE_LIMIT_ADDR;
      csr_pwdata  <= {(CSR_DATA_W - LIMIT_W)'($urandom), limit};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      stale_limit_q = limit;
      // read-back: setup then access, psel held
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[LIMIT_W-1:0] !== limit) begin
         $display("%0t: stale_limit read-back mismatch, expected %0h, actual %0h",
                  $time, limit, csr_prdata[LIMIT_W-1:0]);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   logic [LIMIT_W-1:0] phase_limit [PHASES];

   initial begin
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_key[i]  = ADDR_W'($urandom);
         pool_mac[i]  = MAC_W'({$urandom, $urandom});
         pool_port[i] = random_hop();
         pool_dist[i] = random_hop();
      end
      pool_key[0] = '0;
      pool_key[1] = '1;
      phase_limit = '{16'd0, 16'hFFFF, 16'd1, LIMIT_W'($urandom),
                      16'hFFFE, LIMIT_W'($urandom_range(120, 0))};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words run with the reset stale limit. Fill the table: the
      // all-zero and all-ones keys first, negative port and distance stored
      // as zero on the first add.
      pending_reqs.push_back(make_req(KIND_ADD, '0, '0, HOP_NEGATIVE, HOP_NEGATIVE, '0));
      pending_reqs.push_back(make_req(KIND_ADD, '1, '1, 9'sd255, 9'sd255, '1));
      for (int i = 0; i < SLOTS - 2; i++)
         pending_reqs.push_back(make_req(KIND_ADD, 32'h0A00_0001 + i,
                                         MAC_W'({$urandom, $urandom}),
                                         REQ_HOP_W'(i), REQ_HOP_W'(255 - i),
                                         TIME_W'(i + 1)));
      // add into a full table, then overwrite a present key while full
      pending_reqs.push_back(make_req(KIND_ADD, 32'hC0A8_0101, '1, 9'sd1, 9'sd1, 32'd4));
      pending_reqs.push_back(make_req(KIND_ADD, '1, 48'h0102_0304_0506, 9'sd17, 9'sd3,
                                      32'd5));
      // exact-route lookup, then one with a negative port
      pending_reqs.push_back(make_req(KIND_LOOKUP, '1, 48'h0102_0304_0506, 9'sd17, 9'sd3,
                                      32'd5));
      pending_reqs.push_back(make_req(KIND_LOOKUP, '1, 48'h0102_0304_0506, HOP_NEGATIVE,
                                      9'sd3, 32'd5));
      // update that keeps every stored value, and one that changes them all
      pending_reqs.push_back(make_req(KIND_UPDATE, '1, 48'h00FF_FFFF_FFFF, HOP_NEGATIVE,
                                      HOP_NEGATIVE, 32'd6));
      pending_reqs.push_back(make_req(KIND_UPDATE, 32'h0A00_0001, 48'hA5A5_5A5A_C3C3,
                                      9'sd200, 9'sd0, 32'd7));
      // absent key on update, confirm and delete
      pending_reqs.push_back(make_req(KIND_UPDATE, 32'hC0A8_0101, '1, 9'sd9, 9'sd9, 32'd7));
      pending_reqs.push_back(make_req(KIND_CONFIRM, 32'hC0A8_0101, '0, 9'sd0, 9'sd0, 32'd7));
      pending_reqs.push_back(make_req(KIND_DELETE, 32'hC0A8_0101, '0, 9'sd0, 9'sd0, 32'd7));
      pending_reqs.push_back(make_req(KIND_DELETE, '1, '0, 9'sd0, 9'sd0, 32'd8));
      pending_reqs.push_back(make_req(KIND_UNUSED, '0, '1, HOP_NEGATIVE, HOP_NEGATIVE, '1));
      // purge drops the ten oldest entries of the fill, clear drops the rest
      pending_reqs.push_back(make_req(KIND_PURGE, '0, '0, 9'sd0, 9'sd0, 32'd40));
      pending_reqs.push_back(make_req(KIND_CLEAR, '0, '0, 9'sd0, 9'sd0, 32'd40));
      wait_for_drain();

      // Random phases, each under its own stale limit; the sender pauses at
      // every boundary until all responses are back.
      for (int p = 0; p < PHASES; p++) begin
         write_stale_limit(phase_limit[p]);
         // let the time stamps wrap in one phase
         if (p == 3) gen_now = 32'hFFFF_FFC0;
         repeat (PHASE_ITEMS) pending_reqs.push_back(next_random_req());
         wait_for_drain();
      end

      // watch for stray words after the last response
      repeat (DRAIN_TAIL) @(posedge clock);
      if (errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
